/* hw/rtl/sao45_pkg.sv */
package sao45_pkg;

  // Field widths of a request and of a result.
  localparam int ColW   = 6;
  localparam int PixW   = 8;
  localparam int EdgeW  = 3;
  localparam int OffW   = 8;
  localparam int SignW  = 2;
  localparam int PAddrW = 5;

  // Number of offset registers, one per edge class.
  localparam int NumOffsets = 5;

  // Queue between classification and filtering.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  // Edge class is biased so that it never goes negative.
  localparam logic [EdgeW:0] EdgeBias = 4'd2;

  // Sign codes as stored in the sign line.
  localparam logic [SignW-1:0] SignNeg  = 2'b11;
  localparam logic [SignW-1:0] SignZero = 2'b00;
  localparam logic [SignW-1:0] SignPos  = 2'b01;
  localparam logic [SignW-1:0] SignMin  = 2'b10;

  // What the front end decided to do with a request.
  typedef enum logic [1:0] {
    KIND_PROC,
    KIND_LOAD,
    KIND_DROP
  } kind_e;

  // One queued pixel, classified but not yet offset.
  typedef struct packed {
    logic [ColW-1:0]  column;
    logic [PixW-1:0]  cur_pixel;
    logic [EdgeW-1:0] edge_class;
  } qent_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic                empty;
    logic [FifoCntW-1:0] count;
  } fifo_stat_t;

  // All offsets, entry i for edge class i.
  typedef logic [NumOffsets-1:0][OffW-1:0] offs_t;

endpackage

/* hw/rtl/sao45_ram.sv */
module sao45_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; a read in the same cycle as a
  // write to the same entry returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sao45_front.sv */
module sao45_front #(
  parameter int ROW_WIDTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [sao45_pkg::ColW-1:0]     column_i,
  input  logic [sao45_pkg::PixW-1:0]     cur_pixel_i,
  input  logic [sao45_pkg::PixW-1:0]     below_pixel_i,
  input  logic [sao45_pkg::SignW-1:0]    sign_value_i,
  input  sao45_pkg::fifo_stat_t          fifo_stat_i,
  output logic                           push_o,
  output sao45_pkg::qent_t               push_data_o
);
  import sao45_pkg::*;

  localparam int IdxW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ROW_WIDTH - 1);

  logic              clr_busy_q, clr_busy_d;
  logic [IdxW-1:0]   clr_idx_q, clr_idx_d;

  logic              b_valid_q;
  kind_e             b_kind_q, kind_d;
  logic [ColW-1:0]   b_col_q;
  logic [PixW-1:0]   b_cur_q;
  logic [PixW-1:0]   b_below_q;
  logic [SignW-1:0]  b_sign_q, load_sign_d;
  logic              fwd_q, fwd_d;
  logic [SignW-1:0]  fwd_sign_q;

  logic              accept;
  logic [FifoCntW:0] pending;
  logic [IdxW-1:0]   col_idx;
  logic              col_in_range;

  logic [SignW-1:0]  ram_rdata;
  logic [SignW-1:0]  up_sign;
  logic [SignW-1:0]  sd;
  logic [SignW-1:0]  neg_sd;
  logic [EdgeW:0]    edge_sum;

  logic              b_we;
  logic [IdxW-1:0]   b_waddr;
  logic [SignW-1:0]  b_wdata;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [SignW-1:0]  ram_wdata;

  // A request in stage B enters the queue next edge if it is a pixel to filter, so
  // every one is counted against the free space before a new request is taken.
  assign pending    = {1'b0, fifo_stat_i.count} + (FifoCntW + 1)'(b_valid_q);
  assign in_stall_o = clr_busy_q || (pending >= (FifoCntW + 1)'(FifoDepth));
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the request as it arrives.
  assign col_idx      = IdxW'(column_i);
  assign col_in_range = int'(column_i) < ROW_WIDTH;
  assign load_sign_d  = (sign_value_i == SignMin) ? SignNeg : sign_value_i;

  always_comb begin
    if (!col_in_range) begin
      kind_d = KIND_DROP;
    end else if (opcode_i) begin
      kind_d = KIND_LOAD;
    end else if (column_i == '0) begin
      kind_d = KIND_DROP;
    end else begin
      kind_d = KIND_PROC;
    end
  end

  // Sign of the vertical difference and the resulting edge class.
  always_comb begin
    if (b_cur_q > b_below_q) begin
      sd = SignPos;
    end else if (b_cur_q < b_below_q) begin
      sd = SignNeg;
    end else begin
      sd = SignZero;
    end
  end

  assign neg_sd   = SignW'(~sd + SignW'(1));
  assign up_sign  = fwd_q ? fwd_sign_q : ram_rdata;
  assign edge_sum = {{(EdgeW + 1 - SignW){sd[SignW-1]}}, sd}
                  + {{(EdgeW + 1 - SignW){up_sign[SignW-1]}}, up_sign}
                  + EdgeBias;

  // Stage B writes the sign line: a load primes its own column, a pixel leaves
  // its negated sign for the column to its left.
  always_comb begin
    b_we    = 1'b0;
    b_waddr = IdxW'(b_col_q);
    b_wdata = b_sign_q;
    case (b_kind_q)
      KIND_LOAD: begin
        b_we    = b_valid_q;
        b_waddr = IdxW'(b_col_q);
        b_wdata = b_sign_q;
      end
      KIND_PROC: begin
        b_we    = b_valid_q;
        b_waddr = IdxW'(b_col_q - ColW'(1));
        b_wdata = neg_sd;
      end
      default: begin
        b_we = 1'b0;
      end
    endcase
  end

  // A write landing on the entry being read in the same cycle is forwarded.
  assign fwd_d = b_we && (b_waddr == col_idx);

  // The clearing pass owns the write port right after reset.
  assign ram_we    = clr_busy_q || b_we;
  assign ram_waddr = clr_busy_q ? clr_idx_q : b_waddr;
  assign ram_wdata = clr_busy_q ? SignZero : b_wdata;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + IdxW'(1);
      if (clr_idx_q == LastIdx) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  sao45_ram #(
    .WIDTH (SignW),
    .DEPTH (ROW_WIDTH)
  ) u_sign_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col_idx),
    .rdata_o (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      b_valid_q  <= 1'b0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
      b_valid_q  <= accept;
    end
  end

  // Stage B payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_kind_q   <= kind_d;
      b_col_q    <= column_i;
      b_cur_q    <= cur_pixel_i;
      b_below_q  <= below_pixel_i;
      b_sign_q   <= load_sign_d;
      fwd_q      <= fwd_d;
      fwd_sign_q <= b_wdata;
    end
  end

  // Hand filtered-class pixels to the queue.
  assign push_o                 = b_valid_q && (b_kind_q == KIND_PROC);
  assign push_data_o.column     = b_col_q;
  assign push_data_o.cur_pixel  = b_cur_q;
  assign push_data_o.edge_class = edge_sum[EdgeW-1:0];

endmodule

/* hw/rtl/sao45_fifo.sv */
module sao45_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sao45_pkg::qent_t      push_data_i,
  input  logic                  pop_i,
  output sao45_pkg::qent_t      pop_data_o,
  output sao45_pkg::fifo_stat_t stat_o
);
  import sao45_pkg::*;

  qent_t               entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  // Occupancy follows pushes and pops; the writer never pushes when full.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = entry_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

endmodule

/* hw/rtl/sao45_back.sv */
module sao45_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sao45_pkg::offs_t            offsets_i,
  input  sao45_pkg::fifo_stat_t       fifo_stat_i,
  input  sao45_pkg::qent_t            pop_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sao45_pkg::ColW-1:0]  out_column_o,
  output logic [sao45_pkg::PixW-1:0]  out_pixel_o,
  output logic [sao45_pkg::EdgeW-1:0] edge_class_o
);
  import sao45_pkg::*;

  logic              out_valid_q;
  logic [ColW-1:0]   out_col_q;
  logic [PixW-1:0]   out_pix_q, pix_d;
  logic [EdgeW-1:0]  out_edge_q;
  logic [OffW-1:0]   offset;
  logic [PixW+1:0]   sum;

  // Take the next queued pixel when the output register is free or draining.
  assign pop_o = !fifo_stat_i.empty && (!out_valid_q || !out_stall_i);

  // Offset picked by edge class.
  always_comb begin
    case (pop_data_i.edge_class)
      3'd0:    offset = offsets_i[0];
      3'd1:    offset = offsets_i[1];
      3'd2:    offset = offsets_i[2];
      3'd3:    offset = offsets_i[3];
      default: offset = offsets_i[NumOffsets-1];
    endcase
  end

  // Add the signed offset and clip to the pixel range.
  assign sum = {2'b00, pop_data_i.cur_pixel} + {{2{offset[OffW-1]}}, offset};

  always_comb begin
    if (sum[PixW+1]) begin
      pix_d = '0;
    end else if (sum[PixW]) begin
      pix_d = '1;
    end else begin
      pix_d = sum[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_col_q  <= pop_data_i.column;
      out_pix_q  <= pix_d;
      out_edge_q <= pop_data_i.edge_class;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_column_o = out_col_q;
  assign out_pixel_o  = out_pix_q;
  assign edge_class_o = out_edge_q;

endmodule

/* hw/rtl/sao_edge_offset_diag45.sv */
// Path: an accepted pixel request is registered in stage B, pushed into the
// queue and popped into the result register once that is free or draining.
// Throughput: one request per cycle while in_stall_o is low, set by the sign
// line being read at acceptance and written in the cycle after, with forwarding
// between the two. Reset clears the offsets to zero and then clears the sign
// line, one entry a cycle, with in_stall_o high until the pass is done.
module sao_edge_offset_diag45 #(
  parameter int ROW_WIDTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [sao45_pkg::ColW-1:0]   column_i,
  input  logic [sao45_pkg::PixW-1:0]   cur_pixel_i,
  input  logic [sao45_pkg::PixW-1:0]   below_pixel_i,
  input  logic [sao45_pkg::SignW-1:0]  sign_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sao45_pkg::ColW-1:0]   out_column_o,
  output logic [sao45_pkg::PixW-1:0]   out_pixel_o,
  output logic [sao45_pkg::EdgeW-1:0]  edge_class_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sao45_pkg::PAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import sao45_pkg::*;

  offs_t            offs_q;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  logic             push;
  qent_t            push_data;
  logic             pop;
  qent_t            pop_data;
  fifo_stat_t       fifo_stat;

  // Offset registers, one word each.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PAddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q <= '0;
    end else if (cfg_wr) begin
      for (int i = 0; i < NumOffsets; i++) begin
        if (cfg_idx == 3'(i)) begin
          offs_q[i] <= pwdata[OffW-1:0];
        end
      end
    end
  end

  // Read back the addressed offset; unused addresses read as zero.
  always_comb begin
    prdata = '0;
    for (int i = 0; i < NumOffsets; i++) begin
      if (cfg_idx == 3'(i)) begin
        prdata = {24'd0, offs_q[i]};
      end
    end
  end

  sao45_front #(
    .ROW_WIDTH (ROW_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .column_i      (column_i),
    .cur_pixel_i   (cur_pixel_i),
    .below_pixel_i (below_pixel_i),
    .sign_value_i  (sign_value_i),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  sao45_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  sao45_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .offsets_i    (offs_q),
    .fifo_stat_i  (fifo_stat),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_column_o (out_column_o),
    .out_pixel_o  (out_pixel_o),
    .edge_class_o (edge_class_o)
  );

endmodule

/* hw/rtl/sao45_chk.sv */
module sao45_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sao45_pkg::ColW-1:0]   out_column_o,
  input logic [sao45_pkg::PixW-1:0]   out_pixel_o,
  input logic [sao45_pkg::EdgeW-1:0]  edge_class_o
);
  import sao45_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_column_o)
      && $stable(out_pixel_o) && $stable(edge_class_o))
    else $error("stalled result changed");

  // The edge class never leaves the range of the offset set.
  a_edge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> edge_class_o <= EdgeW'(NumOffsets - 1))
    else $error("edge class out of range");

  // Column zero never yields a filtered pixel.
  a_col_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_column_o != '0)
    else $error("result for column zero");

  // The sign line is being cleared right after reset, so no request is taken.
  a_clear_stall: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request taken during clearing pass");

endmodule

bind sao_edge_offset_diag45 sao45_chk u_chk (.*);

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sao45_pkg::*;

  localparam int RowWidth   = 64;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 4;

  // Request opcodes.
  localparam logic OpProcess = 1'b0;
  localparam logic OpLoad    = 1'b1;

  // Offset register indexes; anything from RegUnused upward is not mapped.
  localparam int RegEdge0  = 0;
  localparam int RegEdge1  = 1;
  localparam int RegEdge2  = 2;
  localparam int RegEdge3  = 3;
  localparam int RegEdge4  = 4;
  localparam int RegUnused = NumOffsets;
  localparam int RegLast   = (1 << PAddrW) / 4 - 1;

  localparam logic [OffW-1:0] OffMax  = 8'sd127;
  localparam logic [OffW-1:0] OffMin  = 8'h80;
  localparam logic [OffW-1:0] OffZero = 8'h00;
  localparam logic [OffW-1:0] OffNeg1 = 8'hff;
  localparam logic [OffW-1:0] OffPos1 = 8'h01;

  typedef struct packed {
    logic [ColW-1:0]  column;
    logic [PixW-1:0]  pixel;
    logic [EdgeW-1:0] edge_class;
  } filtered_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                opcode_i = OpProcess;
  logic [ColW-1:0]     column_i = '0;
  logic [PixW-1:0]     cur_pixel_i = '0;
  logic [PixW-1:0]     below_pixel_i = '0;
  logic [SignW-1:0]    sign_value_i = SignZero;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ColW-1:0]     out_column_o;
  logic [PixW-1:0]     out_pixel_o;
  logic [EdgeW-1:0]    edge_class_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PAddrW-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Mirror of the block: offsets and the sign line of the row above.
  logic signed [OffW-1:0]  edge_offsets [NumOffsets];
  logic signed [SignW-1:0] sign_line [RowWidth];
  filtered_pixel_t         pending_pixels [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  sao_edge_offset_diag45 #(
    .ROW_WIDTH(RowWidth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .column_i     (column_i),
    .cur_pixel_i  (cur_pixel_i),
    .below_pixel_i(below_pixel_i),
    .sign_value_i (sign_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_column_o (out_column_o),
    .out_pixel_o  (out_pixel_o),
    .edge_class_o (edge_class_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Run limit, in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output side: a requested long hold-off wins over random stalls.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expected pixel.
  always @(posedge clk_i) begin
    filtered_pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: column %0d pixel %0d class %0d",
               out_column_o, out_pixel_o, edge_class_o);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_column_o !== want.column) begin
          $error("out_column: expected %0d, got %0d", want.column, out_column_o);
          mismatch_count++;
        end
        if (out_pixel_o !== want.pixel) begin
          $error("out_pixel: expected %0d, got %0d", want.pixel, out_pixel_o);
          mismatch_count++;
        end
        if (edge_class_o !== want.edge_class) begin
          $error("edge_class: expected %0d, got %0d", want.edge_class, edge_class_o);
          mismatch_count++;
        end
      end
    end
  end

  // Work out what one accepted request does to the sign line and the output.
  function automatic void predict_filtered_pixel(logic op, logic [ColW-1:0] col,
                                                 logic [PixW-1:0] cur,
                                                 logic [PixW-1:0] below,
                                                 logic [SignW-1:0] sgn);
    int dir;
    int cls;
    int px;
    filtered_pixel_t res;
    if (op == OpLoad) begin
      // The unused pattern saturates to the negative sign.
      sign_line[col] = (sgn == SignMin) ? SignNeg : sgn;
      return;
    end
    if (col == 0) return;
    dir = (cur > below) ? 1 : ((cur < below) ? -1 : 0);
    cls = dir + int'(sign_line[col]) + 2;
    px = int'(cur) + int'(edge_offsets[cls]);
    if (px < 0) px = 0;
    if (px > 255) px = 255;
    sign_line[col - 1] = SignW'(-dir);
    res.column = col;
    res.pixel = PixW'(px);
    res.edge_class = EdgeW'(cls);
    pending_pixels.push_back(res);
  endfunction

  // Offer one request after random idle cycles and wait until it is taken.
  task automatic send_request(logic op, int col, logic [PixW-1:0] cur,
                              logic [PixW-1:0] below, logic [SignW-1:0] sgn);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    column_i <= ColW'(col);
    cur_pixel_i <= cur;
    below_pixel_i <= below;
    sign_value_i <= sgn;
    do @(posedge clk_i); while (in_stall_o);
    predict_filtered_pixel(op, ColW'(col), cur, below, sgn);
  endtask

  // Stop offering and wait until every expected pixel has come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_offset_reg(int idx, logic [OffW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PAddrW'(idx * 4);
    pwdata <= {{24{value[OffW-1]}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx < NumOffsets) edge_offsets[idx] = value;
    @(posedge clk_i);
  endtask

  task automatic check_offset_reg(int idx);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PAddrW'(idx * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[OffW-1:0] !== edge_offsets[idx]) begin
      $error("prdata offset %0d: expected %0d, got %0d", idx, edge_offsets[idx],
             $signed(got[OffW-1:0]));
      mismatch_count++;
    end
    @(posedge clk_i);
  endtask

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PixW'($urandom);
    endcase
  endfunction

  function automatic logic [OffW-1:0] pick_offset();
    case ($urandom_range(5))
      0: return OffMax;
      1: return OffMin;
      default: return OffW'($urandom);
    endcase
  endfunction

  // Reset values, every register written, unmapped addresses ignored.
  task automatic test_register_access();
    int i;
    for (i = 0; i < NumOffsets; i++) check_offset_reg(i);
    write_offset_reg(RegEdge0, OffMax);
    write_offset_reg(RegEdge1, OffMin);
    write_offset_reg(RegEdge2, OffNeg1);
    write_offset_reg(RegEdge3, OffPos1);
    write_offset_reg(RegEdge4, 8'h5a);
    for (i = RegUnused; i <= RegLast; i++) write_offset_reg(i, OffW'($urandom));
    for (i = 0; i < NumOffsets; i++) check_offset_reg(i);
  endtask

  // Every edge class, clipping at both ends, end columns and saturated signs.
  task automatic test_directed_edges();
    write_offset_reg(RegEdge0, OffMax);
    write_offset_reg(RegEdge1, OffMin);
    write_offset_reg(RegEdge2, OffZero);
    write_offset_reg(RegEdge3, OffNeg1);
    write_offset_reg(RegEdge4, OffPos1);
    send_request(OpLoad,    63, 8'd0,   8'd0,   SignPos);
    send_request(OpProcess, 63, 8'd255, 8'd0,   SignZero);
    send_request(OpProcess, 62, 8'd0,   8'd255, SignZero);
    send_request(OpProcess, 61, 8'd128, 8'd128, SignZero);
    send_request(OpLoad,    5,  8'd0,   8'd0,   SignMin);
    send_request(OpProcess, 5,  8'd10,  8'd10,  SignZero);
    send_request(OpProcess, 4,  8'd200, 8'd100, SignZero);
    send_request(OpProcess, 3,  8'd100, 8'd200, SignZero);
    send_request(OpProcess, 2,  8'd255, 8'd255, SignMin);
    send_request(OpProcess, 1,  8'd0,   8'd0,   SignZero);
    send_request(OpLoad,    0,  8'd255, 8'd255, SignNeg);
    // A pixel at column zero has no left neighbor and is dropped.
    send_request(OpProcess, 0,  8'd50,  8'd20,  SignZero);
    send_request(OpLoad,    1,  8'd0,   8'd0,   SignNeg);
    send_request(OpProcess, 1,  8'd0,   8'd255, SignZero);
    send_request(OpLoad,    63, 8'd0,   8'd0,   SignZero);
    send_request(OpProcess, 63, 8'd0,   8'd0,   SignZero);
    send_request(OpLoad,    10, 8'd255, 8'd255, SignPos);
    send_request(OpProcess, 10, 8'd255, 8'd254, SignNeg);
    send_request(OpProcess, 9,  8'd0,   8'd1,   SignZero);
    send_request(OpProcess, 8,  8'd1,   8'd0,   SignZero);
    wait_idle();
  endtask

  // Mostly right-to-left sweeps that reuse the sign just written, plus
  // scattered pixels, sign loads and dropped column-zero requests.
  task automatic send_pixel_mix(int count);
    int sent;
    int col;
    int len;
    int k;
    logic [PixW-1:0] cur;
    logic [PixW-1:0] below;
    sent = 0;
    while (sent < count) begin
      k = $urandom_range(99);
      if (k < 40) begin
        col = $urandom_range(63, 1);
        len = $urandom_range(12, 2);
        while (len > 0 && col >= 1 && sent < count) begin
          cur = pick_pixel();
          below = ($urandom_range(3) == 0) ? cur : pick_pixel();
          send_request(OpProcess, col, cur, below, SignW'($urandom));
          col--;
          len--;
          sent++;
        end
      end else if (k < 55) begin
        send_request(OpLoad, $urandom_range(63), PixW'($urandom), PixW'($urandom),
                     SignW'($urandom));
        sent++;
      end else if (k < 60) begin
        send_request(OpProcess, 0, PixW'($urandom), PixW'($urandom), SignW'($urandom));
      end else begin
        cur = pick_pixel();
        below = ($urandom_range(3) == 0) ? cur : pick_pixel();
        send_request(OpProcess, $urandom_range(63, 1), cur, below, SignW'($urandom));
        sent++;
      end
    end
  endtask

  // One traffic phase under a given idling pattern and offset setting.
  task automatic test_random_traffic(int send_idle, int recv_stall, int setting,
                                     int count);
    int i;
    for (i = 0; i < NumOffsets; i++) begin
      case (setting)
        0: write_offset_reg(i, OffMax);
        1: write_offset_reg(i, OffMin);
        default: write_offset_reg(i, pick_offset());
      endcase
    end
    sender_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    send_pixel_mix(count);
    wait_idle();
  endtask

  // Output held off long enough for the block to fill and stall its input,
  // then the sender waits for every result before going on.
  task automatic test_backpressure();
    int i;
    for (i = 0; i < NumOffsets; i++) write_offset_reg(i, pick_offset());
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 80;
    send_pixel_mix(40);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    recv_stall_pct = 60;
    send_pixel_mix(20);
    wait_idle();
  endtask

  initial begin
    int i;
    for (i = 0; i < NumOffsets; i++) edge_offsets[i] = '0;
    for (i = 0; i < RowWidth; i++) sign_line[i] = SignZero;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // The block clears its sign line after reset.
    while (in_stall_o) @(posedge clk_i);

    test_register_access();
    test_directed_edges();
    test_random_traffic(0, 0, 2, 170);
    test_random_traffic(60, 0, 0, 170);
    test_random_traffic(0, 60, 1, 170);
    test_random_traffic(28, 28, 2, 170);
    test_backpressure();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sao45_pkg.sv
hw/rtl/sao45_ram.sv
hw/rtl/sao45_front.sv
hw/rtl/sao45_fifo.sv
hw/rtl/sao45_back.sv
hw/rtl/sao_edge_offset_diag45.sv
hw/rtl/sao45_chk.sv
dv/tb.sv
